// ===== sv/tte_pkg.sv =====
// Shared types, codes and helpers for the translation table engine.
// Used by the engine core and tte_hash in this folder; depends on nothing.
package tte_pkg;

    localparam int TABLE_ENTRIES_DEF = 4093;
    localparam int SECTORS_DEF       = 1;
    localparam int HASH_ROT          = 7;
    localparam int KEY_W             = 32;

    localparam logic [16:0] CSW_RESET   = 17'd75302;
    localparam logic [11:0] LIMIT_RESET = 12'd3274;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_INVAL  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_INUSE   = 2'd1;
    localparam logic [1:0] ST_DELETED = 2'd2;

    localparam logic REG_CSW   = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] src_addr;
        logic [15:0] code_bytes;
        logic [1:0]  extent_count;
        logic [31:0] extent_base_a;
        logic [15:0] extent_len_a;
        logic [31:0] extent_base_b;
        logic [15:0] extent_len_b;
        logic [31:0] extent_base_c;
        logic [15:0] extent_len_c;
        logic [31:0] range_len;
    } in_t;

    typedef struct packed {
        logic        found;
        logic [2:0]  slot_sector;
        logic [16:0] host_word_offset;
        logic        any_deleted;
        logic        sector_recycled;
    } out_t;

    // per-slot record held in the entry memory
    typedef struct packed {
        logic [31:0] key;
        logic [16:0] word_offset;
        logic [1:0]  extent_count;
        logic [31:0] base_a;
        logic [15:0] len_a;
        logic [31:0] base_b;
        logic [15:0] len_b;
        logic [31:0] base_c;
        logic [15:0] len_c;
    } entry_t;

    // inclusive ranges; ends are computed modulo 2^32 and compared unsigned
    function automatic logic ranges_meet(input logic [31:0] s1, input logic [31:0] r1,
                                         input logic [31:0] s2, input logic [31:0] r2);
        logic [31:0] e1;
        logic [31:0] e2;
        e1 = s1 + r1 - 32'd1;
        e2 = s2 + r2 - 32'd1;
        return !((e1 < s2) || (e2 < s1));
    endfunction

endpackage

// ===== sv/translation_table_engine_core.sv =====
// Translation table engine top level: sequencer, per-sector counters, config port.
// Depends on tte_pkg, tte_ram and tte_hash.
//
// Usage:
//  - s_ channel carries one request (lookup, insert, invalidate); m_ channel returns
//    exactly one result per request. Both are valid/ready transactions.
//  - One request at a time: s_ready is high only when the sequencer is idle and
//    no result is waiting. A stalled m_ready simply holds the result and s_ready low.
//  - Lookup/insert first hash the key: the upper bits are folded back in one step
//    per cycle, then one conditional subtract.
//  - Each probe is a registered memory read then a compare; a lookup
//    walks at most TABLE_ENTRIES slots per used sector, stopping at an empty slot.
//  - Insert into a sector that is fresh or recycled first sweeps its status
//    memory, one slot per cycle.
//  - Invalidate scans every slot of every used sector.
//  - Reset clears the sequencer and marks all sectors unused; no sweep at reset,
//    a sector is cleared on its first use.
//  - Registers code_store_words (0x0) and entry_limit (0x4) are written via APB; the
//    user must write them only while idle (the block does not enforce it); pready is always high.
module translation_table_engine_core #(
    parameter int TABLE_ENTRIES = tte_pkg::TABLE_ENTRIES_DEF,
    parameter int SECTORS       = tte_pkg::SECTORS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tte_pkg::in_t       s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output tte_pkg::out_t      m_payload,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int IW    = $clog2(TABLE_ENTRIES);
    localparam int SLOTS = SECTORS * TABLE_ENTRIES;
    localparam int AW    = $clog2(SLOTS);
    localparam int SW    = (SECTORS > 1) ? $clog2(SECTORS) : 1;
    localparam int CW    = $clog2(SECTORS + 1);
    localparam logic [IW-1:0] K_LAST  = IW'(TABLE_ENTRIES - 1);
    localparam logic [16:0]   TE_M1   = 17'(TABLE_ENTRIES - 1);
    localparam logic [SW-1:0] S_LAST  = SW'(SECTORS - 1);
    localparam logic [CW-1:0] S_COUNT = CW'(SECTORS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_HASH     = 4'd1;
    localparam logic [3:0] S_LK_SEC   = 4'd2;
    localparam logic [3:0] S_LK_RD    = 4'd3;
    localparam logic [3:0] S_LK_CHK   = 4'd4;
    localparam logic [3:0] S_INS_CHK  = 4'd5;
    localparam logic [3:0] S_CLR      = 4'd6;
    localparam logic [3:0] S_INS_ALOC = 4'd7;
    localparam logic [3:0] S_INS_RD   = 4'd8;
    localparam logic [3:0] S_INS_PRB  = 4'd9;
    localparam logic [3:0] S_INS_WR   = 4'd10;
    localparam logic [3:0] S_INV_SEC  = 4'd11;
    localparam logic [3:0] S_INV_RD   = 4'd12;
    localparam logic [3:0] S_INV_CHK  = 4'd13;
    localparam logic [3:0] S_OUT      = 4'd14;

    logic [3:0]      state_reg;
    logic [3:0]      ret_reg;
    tte_pkg::in_t    req_reg;
    tte_pkg::out_t   res_reg;
    logic            m_valid_reg;
    logic [16:0]     csw_reg;
    logic [11:0]     limit_reg;
    logic [SW-1:0]   young_reg;
    logic [SW-1:0]   s_reg;
    logic [CW-1:0]   secn_reg;
    logic [IW-1:0]   k_reg;
    logic [IW-1:0]   j_reg;
    logic [IW-1:0]   hash_reg;
    logic            used_reg [SECTORS];
    logic [16:0]     nfw_reg  [SECTORS];
    logic [11:0]     cnt_reg  [SECTORS];

    logic            hash_start;
    logic            hash_done;
    logic [IW-1:0]   hash_idx;
    logic [AW-1:0]   slot_addr;
    logic            st_we;
    logic [1:0]      st_wdata;
    logic [1:0]      st_rdata;
    logic            ent_we;
    tte_pkg::entry_t ent_wdata;
    tte_pkg::entry_t ent_rdata;

    logic [SW-1:0]   s_inc;
    logic [SW-1:0]   s_dec;
    logic [IW-1:0]   k_inc;
    logic [13:0]     reqd;
    logic [16:0]     avail;
    logic [16:0]     lim;
    logic [17:0]     nf_sum;
    logic [16:0]     nf;
    logic            overlap;
    logic            s_acc;
    logic            cfg_wr;

    assign s_acc  = s_valid && s_ready;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tte_pkg::REG_LIMIT) ? {20'd0, limit_reg} : {15'd0, csw_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            csw_reg   <= tte_pkg::CSW_RESET;
            limit_reg <= tte_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == tte_pkg::REG_LIMIT) begin
                limit_reg <= pwdata[11:0];
            end else begin
                csw_reg <= pwdata[16:0];
            end
        end
    end

    assign slot_addr = AW'(s_reg) * AW'(TABLE_ENTRIES) + AW'(k_reg);
    assign s_inc     = (s_reg == S_LAST) ? '0 : s_reg + SW'(1);
    assign s_dec     = (s_reg == '0) ? S_LAST : s_reg - SW'(1);
    assign k_inc     = (k_reg == K_LAST) ? '0 : k_reg + IW'(1);

    always_comb begin
        reqd    = 14'((17'(req_reg.code_bytes) + 17'd7) >> 3);
        avail   = (csw_reg > nfw_reg[s_reg]) ? csw_reg - nfw_reg[s_reg] : 17'd0;
        lim     = (17'(limit_reg) > TE_M1) ? TE_M1 : 17'(limit_reg);
        nf_sum  = 18'(nfw_reg[s_reg]) + 18'(reqd);
        nf      = (nf_sum > 18'(csw_reg)) ? csw_reg : nf_sum[16:0];
        if (nf < nfw_reg[s_reg]) nf = nfw_reg[s_reg];
        // extent count zero still checks the first extent
        overlap = tte_pkg::ranges_meet(req_reg.src_addr, req_reg.range_len,
                                       ent_rdata.base_a, 32'(ent_rdata.len_a)) ||
                  ((ent_rdata.extent_count >= 2'd2) &&
                   tte_pkg::ranges_meet(req_reg.src_addr, req_reg.range_len,
                                        ent_rdata.base_b, 32'(ent_rdata.len_b))) ||
                  ((ent_rdata.extent_count == 2'd3) &&
                   tte_pkg::ranges_meet(req_reg.src_addr, req_reg.range_len,
                                        ent_rdata.base_c, 32'(ent_rdata.len_c)));
    end

    always_comb begin
        st_we    = 1'b0;
        st_wdata = tte_pkg::ST_EMPTY;
        ent_we   = 1'b0;
        unique case (state_reg)
            S_CLR: begin
                st_we = 1'b1;
            end
            S_INS_WR: begin
                st_we    = 1'b1;
                st_wdata = tte_pkg::ST_INUSE;
                ent_we   = 1'b1;
            end
            S_INV_CHK: begin
                st_we    = (st_rdata == tte_pkg::ST_INUSE) && overlap;
                st_wdata = tte_pkg::ST_DELETED;
            end
            default: begin
            end
        endcase
        ent_wdata = '{key: req_reg.src_addr, word_offset: res_reg.host_word_offset,
                      extent_count: req_reg.extent_count,
                      base_a: req_reg.extent_base_a, len_a: req_reg.extent_len_a,
                      base_b: req_reg.extent_base_b, len_b: req_reg.extent_len_b,
                      base_c: req_reg.extent_base_c, len_c: req_reg.extent_len_c};
    end

    assign hash_start = s_acc && (s_payload.mode == tte_pkg::MODE_LOOKUP ||
                                  s_payload.mode == tte_pkg::MODE_INSERT);

    tte_hash #(.TABLE_ENTRIES(TABLE_ENTRIES), .IW(IW)) u_hash (
        .aclk(aclk), .aresetn(aresetn), .start(hash_start), .key(s_payload.src_addr),
        .done(hash_done), .index(hash_idx)
    );

    tte_ram #(.WIDTH(2), .DEPTH(SLOTS), .AW(AW)) u_status (
        .aclk(aclk), .we(st_we), .waddr(slot_addr), .wdata(st_wdata),
        .raddr(slot_addr), .rdata(st_rdata)
    );

    tte_ram #(.WIDTH($bits(tte_pkg::entry_t)), .DEPTH(SLOTS), .AW(AW)) u_entry (
        .aclk(aclk), .we(ent_we), .waddr(slot_addr), .wdata(ent_wdata),
        .raddr(slot_addr), .rdata(ent_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            m_valid_reg <= 1'b0;
            young_reg   <= '0;
            for (int i = 0; i < SECTORS; i++) begin
                used_reg[i] <= 1'b0;
                nfw_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        req_reg  <= s_payload;
                        res_reg  <= '0;
                        s_reg    <= '0;
                        secn_reg <= '0;
                        unique case (s_payload.mode)
                            tte_pkg::MODE_LOOKUP: state_reg <= S_HASH;
                            tte_pkg::MODE_INSERT: state_reg <= S_HASH;
                            tte_pkg::MODE_INVAL:  state_reg <= S_INV_SEC;
                            default:              state_reg <= S_OUT;
                        endcase
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        hash_reg <= hash_idx;
                        s_reg    <= young_reg;
                        state_reg <= (req_reg.mode == tte_pkg::MODE_LOOKUP) ? S_LK_SEC
                                                                            : S_INS_CHK;
                    end
                end
                S_LK_SEC: begin
                    if (secn_reg == S_COUNT) begin
                        state_reg <= S_OUT;
                    end else if (used_reg[s_reg]) begin
                        k_reg     <= hash_reg;
                        j_reg     <= '0;
                        state_reg <= S_LK_RD;
                    end else begin
                        s_reg    <= s_dec;
                        secn_reg <= secn_reg + CW'(1);
                    end
                end
                S_LK_RD: state_reg <= S_LK_CHK;
                S_LK_CHK: begin
                    if (st_rdata == tte_pkg::ST_INUSE && ent_rdata.key == req_reg.src_addr) begin
                        res_reg.found            <= 1'b1;
                        res_reg.slot_sector      <= 3'(s_reg);
                        res_reg.host_word_offset <= ent_rdata.word_offset;
                        state_reg                <= S_OUT;
                    end else if (st_rdata == tte_pkg::ST_EMPTY || j_reg == K_LAST) begin
                        s_reg     <= s_dec;
                        secn_reg  <= secn_reg + CW'(1);
                        state_reg <= S_LK_SEC;
                    end else begin
                        k_reg     <= k_inc;
                        j_reg     <= j_reg + IW'(1);
                        state_reg <= S_LK_RD;
                    end
                end
                S_INS_CHK: begin
                    k_reg <= '0;
                    if (!used_reg[s_reg]) begin
                        used_reg[s_reg] <= 1'b1;
                        nfw_reg[s_reg]  <= '0;
                        cnt_reg[s_reg]  <= '0;
                        ret_reg         <= S_INS_CHK;
                        state_reg       <= S_CLR;
                    end else if (17'(reqd) > avail || 17'(cnt_reg[s_reg]) >= lim) begin
                        s_reg           <= s_inc;
                        young_reg       <= s_inc;
                        used_reg[s_inc] <= 1'b1;
                        nfw_reg[s_inc]  <= '0;
                        cnt_reg[s_inc]  <= '0;
                        res_reg.sector_recycled <= 1'b1;
                        ret_reg         <= S_INS_ALOC;
                        state_reg       <= S_CLR;
                    end else begin
                        state_reg <= S_INS_ALOC;
                    end
                end
                S_CLR: begin
                    k_reg <= k_inc;
                    if (k_reg == K_LAST) state_reg <= ret_reg;
                end
                S_INS_ALOC: begin
                    res_reg.found            <= 1'b1;
                    res_reg.slot_sector      <= 3'(s_reg);
                    res_reg.host_word_offset <= nfw_reg[s_reg];
                    nfw_reg[s_reg]           <= nf;
                    cnt_reg[s_reg]           <= cnt_reg[s_reg] + 12'd1;
                    k_reg                    <= hash_reg;
                    j_reg                    <= '0;
                    state_reg                <= S_INS_RD;
                end
                S_INS_RD: state_reg <= S_INS_PRB;
                S_INS_PRB: begin
                    if (st_rdata != tte_pkg::ST_INUSE || j_reg == K_LAST) begin
                        state_reg <= S_INS_WR;
                    end else begin
                        k_reg     <= k_inc;
                        j_reg     <= j_reg + IW'(1);
                        state_reg <= S_INS_RD;
                    end
                end
                S_INS_WR: state_reg <= S_OUT;
                S_INV_SEC: begin
                    if (secn_reg == S_COUNT) begin
                        state_reg <= S_OUT;
                    end else if (used_reg[s_reg]) begin
                        k_reg     <= '0;
                        state_reg <= S_INV_RD;
                    end else begin
                        s_reg    <= s_inc;
                        secn_reg <= secn_reg + CW'(1);
                    end
                end
                S_INV_RD: state_reg <= S_INV_CHK;
                S_INV_CHK: begin
                    if (st_we) begin
                        res_reg.any_deleted <= 1'b1;
                        if (cnt_reg[s_reg] != '0) cnt_reg[s_reg] <= cnt_reg[s_reg] - 12'd1;
                    end
                    if (k_reg == K_LAST) begin
                        s_reg     <= s_inc;
                        secn_reg  <= secn_reg + CW'(1);
                        state_reg <= S_INV_SEC;
                    end else begin
                        k_reg     <= k_inc;
                        state_reg <= S_INV_RD;
                    end
                end
                S_OUT: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid   = m_valid_reg;
    assign m_payload = res_reg;

    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    a_recycle_is_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.sector_recycled |-> m_payload.found && !m_payload.any_deleted)
        else $error("recycle reported outside an insert");

    a_sector_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_payload.slot_sector) < 32'(SECTORS)))
        else $error("result names a sector that does not exist");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("result repeated");
endmodule

// ===== sv/tte_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/tte_hash.sv =====
// Iterative hash: key rotated right, then reduced modulo the table size by folding
// the upper bits back in, one fold per cycle. Depends on tte_pkg.
module tte_hash #(
    parameter int TABLE_ENTRIES = tte_pkg::TABLE_ENTRIES_DEF,
    parameter int IW            = $clog2(TABLE_ENTRIES)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [31:0]   key,
    output logic          done,
    output logic [IW-1:0] index
);
    localparam int RW = IW + 1;
    localparam int HW = tte_pkg::KEY_W - IW;
    // weight of the bits above IW: 2^IW mod TABLE_ENTRIES
    localparam logic [IW-1:0] FOLD_W = IW'((1 << IW) - TABLE_ENTRIES);
    localparam logic [RW-1:0] TE     = RW'(TABLE_ENTRIES);

    logic [31:0]   x_reg;
    logic [IW-1:0] idx_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [HW-1:0] hi;
    logic [IW-1:0] lo;
    logic [RW-1:0] lo_ext;
    logic [31:0]   x_next;
    logic [IW-1:0] idx_next;

    // hi*2^IW + lo == hi*FOLD_W + lo (mod table size); strictly shrinks while hi != 0
    always_comb begin
        hi       = x_reg[31:IW];
        lo       = x_reg[IW-1:0];
        lo_ext   = {1'b0, lo};
        x_next   = 32'(hi) * 32'(FOLD_W) + 32'(lo);
        idx_next = (lo_ext >= TE) ? IW'(lo_ext - TE) : lo;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                x_reg    <= (key >> tte_pkg::HASH_ROT) |
                            (key << (tte_pkg::KEY_W - tte_pkg::HASH_ROT));
            end else if (busy_reg) begin
                if (hi != '0) begin
                    x_reg <= x_next;
                end else begin
                    idx_reg  <= idx_next;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign index = idx_reg;
endmodule

// ===== test/tb_top.sv =====
// Testbench for translation_table_engine_core: directed and random lookup, insert and
// invalidate transactions checked against an in-bench model of the sector hash table.
// Depends on tte_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int TE       = tte_pkg::TABLE_ENTRIES_DEF;
    localparam int NSEC     = tte_pkg::SECTORS_DEF;
    localparam int WATCHDOG = 200000;
    localparam logic [2:0] ADDR_CSW   = 3'd0;
    localparam logic [2:0] ADDR_LIMIT = 3'd4;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    tte_pkg::in_t  s_payload;
    logic m_valid;
    logic m_ready;
    tte_pkg::out_t m_payload;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    translation_table_engine_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // table model
    logic [16:0] store_words_m;
    logic [11:0] limit_m;
    int unsigned youngest_m;
    bit          sector_used_m [NSEC];
    logic [16:0] next_free_m [NSEC];
    int unsigned in_use_m [NSEC];
    logic [1:0]  status_m [NSEC][TE];
    tte_pkg::entry_t rec_m [NSEC][TE];

    tte_pkg::out_t expected_results[$];
    int   mismatches;
    bit   no_idle;
    logic [31:0] key_pool [32];

    function automatic int unsigned bucket_of(logic [31:0] k);
        logic [31:0] r;
        r = {k[6:0], k[31:7]};
        return r % TE;
    endfunction

    // key in the same bucket as k: m table sizes are added to its rotated form (unless the sum wraps past 2^32)
    function automatic logic [31:0] neighbor_key(logic [31:0] k, int unsigned m);
        logic [31:0] r;
        r = {k[6:0], k[31:7]} + m * TE;
        return {r[24:0], r[31:25]};
    endfunction

    function automatic bit spans_overlap(logic [31:0] a, logic [31:0] alen,
                                         logic [31:0] b, logic [31:0] blen);
        logic [31:0] a_end;
        logic [31:0] b_end;
        a_end = a + alen - 32'd1;
        b_end = b + blen - 32'd1;
        return !((a_end < b) || (b_end < a));
    endfunction

    function automatic void wipe_sector(int unsigned s);
        for (int i = 0; i < TE; i++) status_m[s][i] = tte_pkg::ST_EMPTY;
        next_free_m[s] = '0;
        in_use_m[s] = 0;
        sector_used_m[s] = 1'b1;
    endfunction

    function automatic void reset_model();
        store_words_m = tte_pkg::CSW_RESET;
        limit_m = tte_pkg::LIMIT_RESET;
        youngest_m = 0;
        for (int s = 0; s < NSEC; s++) begin
            sector_used_m[s] = 1'b0;
            next_free_m[s] = '0;
            in_use_m[s] = 0;
            for (int i = 0; i < TE; i++) status_m[s][i] = tte_pkg::ST_EMPTY;
        end
    endfunction

    function automatic tte_pkg::out_t table_response(tte_pkg::in_t rq);
        tte_pkg::out_t res;
        int unsigned s, k, lim, reqd, avail, nf, slot, n;
        tte_pkg::entry_t e;
        logic [31:0] bases [3];
        logic [31:0] lens [3];
        res = '0;
        if (youngest_m >= NSEC) youngest_m = 0;
        case (rq.mode)
            tte_pkg::MODE_LOOKUP: begin
                s = youngest_m;
                for (int i = 0; i < NSEC && !res.found; i++) begin
                    if (sector_used_m[s]) begin
                        k = bucket_of(rq.src_addr);
                        for (int j = 0; j < TE; j++) begin
                            if (status_m[s][k] == tte_pkg::ST_INUSE &&
                                rec_m[s][k].key == rq.src_addr) begin
                                res.found = 1'b1;
                                res.slot_sector = 3'(s);
                                res.host_word_offset = rec_m[s][k].word_offset;
                                break;
                            end
                            if (status_m[s][k] == tte_pkg::ST_EMPTY) break;
                            k = (k + 1 >= TE) ? 0 : k + 1;
                        end
                    end
                    s = (s == 0) ? NSEC - 1 : s - 1;
                end
            end
            tte_pkg::MODE_INSERT: begin
                reqd = (int'(rq.code_bytes) + 7) >> 3;
                lim = (limit_m > TE - 1) ? TE - 1 : limit_m;
                s = youngest_m;
                if (!sector_used_m[s]) wipe_sector(s);
                avail = (store_words_m > next_free_m[s]) ? store_words_m - next_free_m[s] : 0;
                if (avail < reqd || in_use_m[s] >= lim) begin
                    s = (s + 1 >= NSEC) ? 0 : s + 1;
                    youngest_m = s;
                    wipe_sector(s);
                    res.sector_recycled = 1'b1;
                end
                res.host_word_offset = next_free_m[s];
                nf = next_free_m[s] + reqd;
                if (nf > store_words_m) nf = store_words_m;
                if (nf < next_free_m[s]) nf = next_free_m[s];
                next_free_m[s] = nf[16:0];
                in_use_m[s]++;
                k = bucket_of(rq.src_addr);
                slot = k;
                for (int j = 0; j < TE; j++) begin
                    slot = k;
                    if (status_m[s][k] != tte_pkg::ST_INUSE) break;
                    k = (k + 1 >= TE) ? 0 : k + 1;
                end
                e.key = rq.src_addr;
                e.word_offset = res.host_word_offset;
                e.extent_count = rq.extent_count;
                e.base_a = rq.extent_base_a;
                e.len_a = rq.extent_len_a;
                e.base_b = rq.extent_base_b;
                e.len_b = rq.extent_len_b;
                e.base_c = rq.extent_base_c;
                e.len_c = rq.extent_len_c;
                status_m[s][slot] = tte_pkg::ST_INUSE;
                rec_m[s][slot] = e;
                res.found = 1'b1;
                res.slot_sector = 3'(s);
            end
            tte_pkg::MODE_INVAL: begin
                for (s = 0; s < NSEC; s++) begin
                    if (!sector_used_m[s]) continue;
                    for (int i = 0; i < TE; i++) begin
                        if (status_m[s][i] != tte_pkg::ST_INUSE) continue;
                        e = rec_m[s][i];
                        bases[0] = e.base_a; lens[0] = {16'd0, e.len_a};
                        bases[1] = e.base_b; lens[1] = {16'd0, e.len_b};
                        bases[2] = e.base_c; lens[2] = {16'd0, e.len_c};
                        n = (e.extent_count == 0) ? 1 : e.extent_count;
                        for (int x = 0; x < n; x++) begin
                            if (spans_overlap(rq.src_addr, rq.range_len, bases[x], lens[x])) begin
                                status_m[s][i] = tte_pkg::ST_DELETED;
                                if (in_use_m[s] > 0) in_use_m[s]--;
                                res.any_deleted = 1'b1;
                                break;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // random gap: mostly none, sometimes short, rarely long
    function automatic int unsigned idle_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(tte_pkg::in_t rq);
        int unsigned gap;
        gap = idle_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_payload = rq;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(table_response(rq));
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] a, logic [31:0] d);
        @(negedge aclk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = a; pwdata = d;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic apb_check(logic [2:0] a, logic [31:0] want);
        @(negedge aclk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = a;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (prdata !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("register 0x%0h read: expected %0h got %0h", a, want, prdata);
        end
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0;
    endtask

    task automatic set_regs(logic [16:0] csw, logic [11:0] lim);
        drain();
        apb_write(ADDR_CSW, {15'd0, csw});
        apb_write(ADDR_LIMIT, {20'd0, lim});
        store_words_m = csw;
        limit_m = lim;
        apb_check(ADDR_CSW, {15'd0, csw});
        apb_check(ADDR_LIMIT, {20'd0, lim});
    endtask

    function automatic tte_pkg::in_t lookup_req(logic [31:0] k);
        tte_pkg::in_t rq;
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        rq = raw[$bits(tte_pkg::in_t)-1:0];
        rq.mode = tte_pkg::MODE_LOOKUP;
        rq.src_addr = k;
        return rq;
    endfunction

    function automatic tte_pkg::in_t insert_req(logic [31:0] k, logic [15:0] len,
                                                logic [1:0] cnt,
                                                logic [31:0] ba, logic [15:0] la);
        tte_pkg::in_t rq;
        rq = lookup_req(k);
        rq.mode = tte_pkg::MODE_INSERT;
        rq.code_bytes = len;
        rq.extent_count = cnt;
        rq.extent_base_a = ba;
        rq.extent_len_a = la;
        return rq;
    endfunction

    function automatic tte_pkg::in_t inval_req(logic [31:0] a, logic [31:0] rlen);
        tte_pkg::in_t rq;
        rq = lookup_req(a);
        rq.mode = tte_pkg::MODE_INVAL;
        rq.range_len = rlen;
        return rq;
    endfunction

    task automatic test_basic_modes();
        tte_pkg::in_t rq;
        logic [31:0] twin;
        twin = neighbor_key(32'hFFFF_FFFF, 0) ^ 32'h0;
        twin = neighbor_key(32'hFFFF_FFFF, 1);
        send_request(lookup_req(32'h0));            // nothing used yet
        rq = '1;
        rq.mode = tte_pkg::MODE_NONE;                // unused mode
        send_request(rq);
        // first use of the sector; extent count zero, extent wraps past the top
        send_request(insert_req(32'hFFFF_FFFF, 16'd1, 2'd0, 32'hFFFF_FFF0, 16'h0020));
        rq = insert_req(twin, 16'hFFFF, 2'd3, 32'h0, 16'd0);
        rq.extent_base_b = 32'hFFFF_FFFF; rq.extent_len_b = 16'hFFFF;
        rq.extent_base_c = 32'h8000_0000; rq.extent_len_c = 16'h0001;
        send_request(rq);
        rq = insert_req(32'h0, 16'd0, 2'd1, 32'h1000, 16'h0010);
        rq.code_bytes = 16'd0;
        send_request(rq);
        send_request(lookup_req(32'hFFFF_FFFF));
        send_request(lookup_req(twin));
        send_request(lookup_req(32'h0));
        send_request(lookup_req(neighbor_key(32'hFFFF_FFFF, 2)));
        send_request(inval_req(32'h0000_0005, 32'd1));   // hits only twin, via its zero-length first extent
        send_request(lookup_req(32'hFFFF_FFFF));
        send_request(lookup_req(twin));                  // probes past the deleted slot
        send_request(inval_req(32'h0, 32'hFFFF_FFFF));
        send_request(inval_req(32'h0, 32'hFFFF_FFFF));   // nothing left
        send_request(lookup_req(twin));
    endtask

    task automatic test_entry_limit();
        set_regs(tte_pkg::CSW_RESET, 12'd0);
        for (int i = 0; i < 3; i++)
            send_request(insert_req($urandom, 16'($urandom_range(1, 64)), 2'd1,
                                    $urandom, 16'd8));
        set_regs(tte_pkg::CSW_RESET, 12'hFFF);       // above the table size
        for (int i = 0; i < 3; i++)
            send_request(insert_req(32'h55 + i, 16'd8, 2'd2, $urandom, 16'd8));
        send_request(lookup_req(32'h56));
        set_regs(tte_pkg::CSW_RESET, 12'd1);
        send_request(insert_req(32'hA5A5_0000, 16'd9, 2'd1, 32'h0, 16'd4));
        send_request(insert_req(32'h5A5A_FFFF, 16'd9, 2'd1, 32'h0, 16'd4));
        send_request(lookup_req(32'hA5A5_0000));
    endtask

    task automatic test_store_capacity();
        set_regs(17'h1FFFF, 12'd4093);
        for (int i = 0; i < 3; i++)
            send_request(insert_req(32'h100 + i, 16'hFFFF, 2'd1, $urandom, 16'hFFFF));
        set_regs(17'd1, 12'd4093);                   // store shrank below the free word
        send_request(insert_req(32'h200, 16'd8, 2'd1, 32'h0, 16'd1));
        send_request(insert_req(32'h201, 16'hFFFF, 2'd1, 32'h0, 16'd1));  // never fits
        send_request(insert_req(32'h202, 16'd1, 2'd1, 32'h0, 16'd1));
        send_request(lookup_req(32'h201));
    endtask

    function automatic logic [31:0] extent_base();
        return ($urandom_range(0, 9) == 0) ? $urandom : 32'h4000_0000 + $urandom_range(0, 65535);
    endfunction

    task automatic test_random_traffic(int unsigned count, logic [16:0] csw, logic [11:0] lim);
        tte_pkg::in_t rq;
        int unsigned p;
        logic [31:0] seed_key;
        set_regs(csw, lim);
        no_idle = ($urandom_range(0, 3) == 0);
        seed_key = $urandom;
        for (int i = 0; i < 32; i++)
            key_pool[i] = (i < 16) ? neighbor_key(seed_key, i % 6) : $urandom;
        for (int n = 0; n < count; n++) begin
            p = $urandom_range(0, 99);
            rq = lookup_req((p % 7 == 0) ? $urandom : key_pool[$urandom_range(0, 31)]);
            if (p < 2) begin
                rq.mode = tte_pkg::MODE_NONE;
            end else if (p < 6) begin
                rq.mode = tte_pkg::MODE_INVAL;
                rq.src_addr = extent_base();
                if ($urandom_range(0, 4) != 0) rq.range_len = $urandom_range(1, 4096);
            end else if (p < 50) begin
                rq.mode = tte_pkg::MODE_INSERT;
                if ($urandom_range(0, 7) != 0) rq.code_bytes = 16'($urandom_range(1, 512));
                rq.extent_base_a = extent_base();
                rq.extent_base_b = extent_base();
                rq.extent_base_c = extent_base();
                if ($urandom_range(0, 3) != 0) rq.extent_len_a = 16'($urandom_range(0, 256));
            end
            send_request(rq);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        tte_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction %p", m_payload);
            end else begin
                want = expected_results.pop_front();
                if (m_payload.found !== want.found ||
                    m_payload.slot_sector !== want.slot_sector ||
                    m_payload.host_word_offset !== want.host_word_offset ||
                    m_payload.any_deleted !== want.any_deleted ||
                    m_payload.sector_recycled !== want.sector_recycled) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p got %p", want, m_payload);
                end
            end
        end
    end

    // result-side backpressure
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = idle_gap();
            if (stall == 0) begin
                m_ready = 1'b1;
            end else begin
                m_ready = 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        mismatches = 0;
        no_idle = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        reset_model();
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        test_basic_modes();
        test_entry_limit();
        test_store_capacity();
        test_random_traffic(380, tte_pkg::CSW_RESET, tte_pkg::LIMIT_RESET);
        test_random_traffic(380, 17'd200, 12'd20);
        test_random_traffic(380, 17'h1FFFF, 12'd4093);
        test_random_traffic(380, 17'd5000, 12'd60);
        drain();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
